FILE: rtl/core/dimacs_cnf_stream_parser_unit_macros.svh
// assertion macros shared by the parser rtl
`ifndef DIMACS_CNF_STREAM_PARSER_UNIT_MACROS_SVH
`define DIMACS_CNF_STREAM_PARSER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define DCP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define DCP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DCP_ASSERT_IMP(label, ante, cons, msg)
`define DCP_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

FILE: rtl/core/dcp_pkg.sv
package dcp_pkg;

  localparam int NumberBits = 32;
  localparam int LineBits   = 24;
  localparam int ColumnBits = 16;

  localparam int MagW     = NumberBits - 1;
  localparam int ProdW    = MagW + 4;
  localparam int ValueW   = 32;
  localparam int CountW   = 31;
  localparam int LineOutW = 24;
  localparam int ColOutW  = 16;

  localparam int FifoDepth = 2;
  localparam int FifoPtrW  = $clog2(FifoDepth);
  localparam int FifoCntW  = $clog2(FifoDepth + 1);

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChNl    = 8'h0a;
  localparam logic [7:0] ChC     = 8'h63;
  localparam logic [7:0] ChN     = 8'h6e;
  localparam logic [7:0] ChF     = 8'h66;
  localparam logic [7:0] ChP     = 8'h70;
  localparam logic [7:0] ChPct   = 8'h25;
  localparam logic [7:0] ChMinus = 8'h2d;
  localparam logic [7:0] ChPlus  = 8'h2b;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  typedef enum logic [3:0] {
    ModeLine,
    ModeSkip,
    ModeHalt,
    ModeFmtWs,
    ModeFmtN,
    ModeFmtF,
    ModeVarsWs,
    ModeVars,
    ModeClsWs,
    ModeCls,
    ModeClWs,
    ModeLit
  } mode_e;

  typedef enum logic [2:0] {
    KindHeader,
    KindLiteral,
    KindClauseEnd,
    KindDone,
    KindTrivSat,
    KindError
  } kind_e;

  typedef enum logic [2:0] {
    ErrDupHeader,
    ErrNotCnf,
    ErrNegVars,
    ErrNegClauses,
    ErrNoTerm,
    ErrBadLiteral,
    ErrNoHeader,
    ErrOverflow
  } err_e;

  typedef struct packed {
    mode_e                 mode;
    logic                  hdr;
    logic [MagW-1:0]       acc;
    logic                  neg;
    logic                  dig;
    logic [MagW-1:0]       held;
    logic [LineBits-1:0]   line;
    logic [ColumnBits-1:0] colc;
  } state_t;

  typedef struct packed {
    kind_e                     kind;
    logic signed [ValueW-1:0]  value;
    logic [CountW-1:0]         clause_count;
    err_e                      error_code;
    logic [LineOutW-1:0]       line_number;
    logic [ColOutW-1:0]        column;
    logic                      last_of_run;
  } res_t;

  function automatic res_t mk_plain(kind_e k);
    res_t r;
    r              = '0;
    r.kind         = k;
    r.error_code   = ErrDupHeader;
    return r;
  endfunction

endpackage

FILE: rtl/core/dcp_stream_if.sv
interface dcp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_input;

  modport source (output valid, output text_byte, output end_of_input, input ready);
  modport sink (input valid, input text_byte, input end_of_input, output ready);
endinterface

interface dcp_out_if;
  import dcp_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [2:0]               kind;
  logic signed [ValueW-1:0] value;
  logic [CountW-1:0]        clause_count;
  logic [2:0]               error_code;
  logic [LineOutW-1:0]      line_number;
  logic [ColOutW-1:0]       column;
  logic                     last_of_run;

  modport source (
    output valid, output kind, output value, output clause_count, output error_code,
    output line_number, output column, output last_of_run, input ready
  );
  modport sink (
    input valid, input kind, input value, input clause_count, input error_code,
    input line_number, input column, input last_of_run, output ready
  );
endinterface

FILE: rtl/core/dcp_step.sv
module dcp_step (
  input  dcp_pkg::state_t state_i,
  input  logic [7:0]      text_byte_i,
  input  logic            end_of_input_i,
  output dcp_pkg::state_t state_o,
  output dcp_pkg::res_t   res0_o,
  output dcp_pkg::res_t   res1_o,
  output logic [1:0]      count_o
);
  import dcp_pkg::*;

  logic                  is_ws;
  logic                  is_nl;
  logic                  is_dig;
  logic                  is_sign;
  logic [ColumnBits-1:0] col;
  logic [3:0]            digit;
  logic [ProdW-1:0]      prod;
  logic                  ovf;
  logic                  fall;
  mode_e                 eff;

  logic  fail;
  err_e  fcode;
  logic  fin;
  logic  ev;
  logic  ev_more;
  logic  add;
  state_t st_d;
  res_t   r0;
  res_t   r1;
  logic [1:0] n;

  assign is_ws   = (text_byte_i == ChSpace) || (text_byte_i == ChTab);
  assign is_nl   = (text_byte_i == ChNl);
  assign is_dig  = (text_byte_i >= ChZero) && (text_byte_i <= ChNine);
  assign is_sign = (text_byte_i == ChMinus) || (text_byte_i == ChPlus);
  assign col     = (state_i.colc != '1) ? state_i.colc + ColumnBits'(1) : state_i.colc;
  assign digit   = text_byte_i[3:0];

  // acc * 10 + digit, checked against the largest magnitude
  assign prod = (ProdW'(state_i.acc) << 3) + (ProdW'(state_i.acc) << 1) + ProdW'(digit);
  assign ovf  = prod > ProdW'({MagW{1'b1}});

  // a clause line starts on its first character and is decoded in the same step
  assign fall = (state_i.mode == ModeLine) && !is_ws && !is_nl && (text_byte_i != ChC) &&
                (text_byte_i != ChPct) && (text_byte_i != ChP) && state_i.hdr;
  assign eff  = fall ? ModeClWs : state_i.mode;

  always_comb begin
    st_d    = state_i;
    r0      = mk_plain(KindDone);
    r1      = mk_plain(KindDone);
    n       = 2'd0;
    fail    = 1'b0;
    fcode   = ErrDupHeader;
    fin     = 1'b0;
    ev      = 1'b0;
    ev_more = 1'b0;
    add     = 1'b0;

    if (state_i.mode == ModeHalt) begin
      st_d = state_i;
    end else if (end_of_input_i) begin
      unique case (state_i.mode) inside
        ModeLine, ModeSkip: begin
          n = 2'd1;
        end
        ModeFmtWs, ModeFmtN, ModeFmtF: begin
          fail  = 1'b1;
          fcode = ErrNotCnf;
        end
        ModeVarsWs, ModeVars: ev  = 1'b1;
        ModeClsWs, ModeCls:   fin = 1'b1;
        default: begin
          fail  = 1'b1;
          fcode = ErrNoTerm;
        end
      endcase
    end else begin
      st_d.colc = col;
      unique case (eff) inside
        ModeLine: begin
          if (is_ws || is_nl) begin
            st_d.mode = ModeLine;
          end else if (text_byte_i == ChC) begin
            st_d.mode = ModeSkip;
          end else if (text_byte_i == ChPct) begin
            st_d.mode = ModeHalt;
            n         = 2'd1;
          end else if (text_byte_i == ChP) begin
            if (state_i.hdr) begin
              fail  = 1'b1;
              fcode = ErrDupHeader;
            end else begin
              st_d.hdr  = 1'b1;
              st_d.mode = ModeFmtWs;
            end
          end else begin
            fail  = 1'b1;
            fcode = ErrNoHeader;
          end
        end
        ModeSkip: st_d.mode = ModeSkip;
        ModeFmtWs: begin
          if (text_byte_i == ChC) begin
            st_d.mode = ModeFmtN;
          end else if (!is_ws) begin
            fail  = 1'b1;
            fcode = ErrNotCnf;
          end
        end
        ModeFmtN: begin
          if (text_byte_i == ChN) begin
            st_d.mode = ModeFmtF;
          end else begin
            fail  = 1'b1;
            fcode = ErrNotCnf;
          end
        end
        ModeFmtF: begin
          if (text_byte_i == ChF) begin
            st_d.acc  = '0;
            st_d.neg  = 1'b0;
            st_d.dig  = 1'b0;
            st_d.mode = ModeVarsWs;
          end else begin
            fail  = 1'b1;
            fcode = ErrNotCnf;
          end
        end
        ModeVarsWs, ModeClsWs: begin
          if (is_ws) begin
            st_d.mode = state_i.mode;
          end else if (is_sign) begin
            st_d.neg  = (text_byte_i == ChMinus);
            st_d.mode = (state_i.mode == ModeVarsWs) ? ModeVars : ModeCls;
          end else if (is_dig) begin
            add       = 1'b1;
            st_d.mode = (state_i.mode == ModeVarsWs) ? ModeVars : ModeCls;
          end else if (state_i.mode == ModeVarsWs) begin
            ev = 1'b1;
          end else begin
            fin = 1'b1;
          end
        end
        ModeVars: begin
          if (is_dig) begin
            add = 1'b1;
          end else begin
            ev      = 1'b1;
            ev_more = is_ws;
          end
        end
        ModeCls: begin
          if (is_dig) add = 1'b1;
          else        fin = 1'b1;
        end
        ModeClWs: begin
          if (is_ws) begin
            st_d.mode = ModeClWs;
          end else if (is_nl) begin
            fail  = 1'b1;
            fcode = ErrNoTerm;
          end else if (text_byte_i == ChZero) begin
            r0        = mk_plain(KindClauseEnd);
            n         = 2'd1;
            st_d.mode = ModeSkip;
          end else if (is_sign) begin
            st_d.acc  = '0;
            st_d.dig  = 1'b0;
            st_d.neg  = (text_byte_i == ChMinus);
            st_d.mode = ModeLit;
          end else if (is_dig) begin
            // a single digit never overflows
            st_d.acc  = MagW'(digit);
            st_d.dig  = 1'b1;
            st_d.neg  = 1'b0;
            st_d.mode = ModeLit;
          end else begin
            fail  = 1'b1;
            fcode = ErrBadLiteral;
          end
        end
        ModeLit: begin
          if (is_dig) begin
            add = 1'b1;
          end else if (is_ws) begin
            if (!state_i.dig || state_i.acc == '0) begin
              fail  = 1'b1;
              fcode = ErrBadLiteral;
            end else begin
              r0       = mk_plain(KindLiteral);
              r0.value = state_i.neg ? -(ValueW'(state_i.acc)) : ValueW'(state_i.acc);
              n        = 2'd1;
              st_d.acc  = '0;
              st_d.neg  = 1'b0;
              st_d.dig  = 1'b0;
              st_d.mode = ModeClWs;
            end
          end else if (is_nl) begin
            fail  = 1'b1;
            fcode = ErrNoTerm;
          end else begin
            fail  = 1'b1;
            fcode = ErrBadLiteral;
          end
        end
        default: st_d.mode = ModeHalt;
      endcase
    end

    if (add) begin
      if (ovf) begin
        fail  = 1'b1;
        fcode = ErrOverflow;
      end else begin
        st_d.acc = prod[MagW-1:0];
        st_d.dig = 1'b1;
      end
    end

    // end of the variable count
    if (ev) begin
      if (state_i.neg && state_i.acc != '0) begin
        fail  = 1'b1;
        fcode = ErrNegVars;
      end else begin
        st_d.held = state_i.acc;
        st_d.acc  = '0;
        st_d.neg  = 1'b0;
        st_d.dig  = 1'b0;
        if (ev_more) begin
          st_d.mode = ModeClsWs;
        end else begin
          // clause count left empty reads as zero
          st_d.mode = ModeHalt;
          r0        = mk_plain(KindTrivSat);
          n         = 2'd1;
        end
      end
    end

    // end of the clause count
    if (fin) begin
      if (state_i.neg && state_i.acc != '0) begin
        fail  = 1'b1;
        fcode = ErrNegClauses;
      end else begin
        st_d.acc = '0;
        st_d.neg = 1'b0;
        st_d.dig = 1'b0;
        n        = 2'd1;
        if (state_i.held == '0 || state_i.acc == '0) begin
          st_d.mode = ModeHalt;
          r0        = mk_plain(KindTrivSat);
        end else begin
          st_d.mode       = ModeSkip;
          r0              = mk_plain(KindHeader);
          r0.value        = ValueW'(state_i.held);
          r0.clause_count = CountW'(state_i.acc);
        end
      end
    end

    if (fail) begin
      st_d.mode      = ModeHalt;
      r0             = mk_plain(KindError);
      r0.error_code  = fcode;
      r0.line_number = LineOutW'(state_i.line);
      r0.column      = ColOutW'(col);
      n              = 2'd1;
    end

    if (end_of_input_i && state_i.mode != ModeHalt) begin
      st_d.mode = ModeHalt;
      if (n == 2'd1 && r0.kind == KindHeader) n = 2'd2;
    end

    if (!end_of_input_i && is_nl && st_d.mode != ModeHalt) begin
      st_d.mode = ModeLine;
      st_d.colc = '0;
      if (state_i.line != '1) st_d.line = state_i.line + LineBits'(1);
    end

    if (n == 2'd1) r0.last_of_run = 1'b1;
    if (n == 2'd2) r1.last_of_run = 1'b1;
  end

  assign state_o = st_d;
  assign res0_o  = r0;
  assign res1_o  = r1;
  assign count_o = n;

endmodule

FILE: rtl/core/dcp_res_fifo.sv
`include "dimacs_cnf_stream_parser_unit_macros.svh"

module dcp_res_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  dcp_pkg::res_t data_i,
  output logic          full_o,
  output logic          valid_o,
  output dcp_pkg::res_t data_o,
  input  logic          pop_i
);
  import dcp_pkg::*;

  res_t                mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_q;
  logic [FifoPtrW-1:0] rd_q;
  logic [FifoCntW-1:0] cnt_q;
  logic                do_push;
  logic                do_pop;

  assign full_o  = (cnt_q == FifoCntW'(FifoDepth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + FifoPtrW'(1);
      if (do_pop)  rd_q <= rd_q + FifoPtrW'(1);
      if (do_push && !do_pop)      cnt_q <= cnt_q + FifoCntW'(1);
      else if (!do_push && do_pop) cnt_q <= cnt_q - FifoCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

  `DCP_ASSERT_IMP(a_fifo_no_drop, push_i, !full_o, "result pushed into full queue")

endmodule

FILE: rtl/core/dimacs_cnf_stream_parser_unit.sv
// dimacs cnf stream parser
// in_i carries one text byte per transfer, or an end-of-input mark (byte ignored).
// out_o carries decoded items: header, literal, clause end, done, trivially
// satisfiable or error (with error code, line and column of the offending byte).
// last_of_run flags the final item caused by one input transfer.
// a byte taken into the input register is decoded in a single pass into a
// two-entry result queue; one byte is taken every cycle unless a pending item
// or a full queue stalls the decode. an end of input that closes a header gives
// the header and then done, the second item waiting in the pending register.
// after done, trivially satisfiable or an error the parser halts: bytes are still
// taken but give no items until reset.
// reset (rst_ni low) returns to the start of line one with no header seen and
// empties the result queue.
// when out_o stalls the queue fills and in_i.ready drops; nothing is lost.
`include "dimacs_cnf_stream_parser_unit_macros.svh"

module dimacs_cnf_stream_parser_unit (
  input  logic            clk_i,
  input  logic            rst_ni,
  dcp_in_if.sink          in_i,
  dcp_out_if.source       out_o
);
  import dcp_pkg::*;

  logic       stage_v_q;
  logic [7:0] stage_byte_q;
  logic       stage_eoi_q;
  state_t     state_q;
  logic       pend_q;
  res_t       pend_res_q;

  state_t     step_state;
  res_t       step_res0;
  res_t       step_res1;
  logic [1:0] step_cnt;
  logic       step_go;
  logic       accept;
  logic       push;
  res_t       push_data;
  logic       fifo_full;
  logic       fifo_valid;
  res_t       fifo_data;

  dcp_step u_step (
    .state_i        (state_q),
    .text_byte_i    (stage_byte_q),
    .end_of_input_i (stage_eoi_q),
    .state_o        (step_state),
    .res0_o         (step_res0),
    .res1_o         (step_res1),
    .count_o        (step_cnt)
  );

  assign step_go    = stage_v_q && !pend_q && !fifo_full;
  assign in_i.ready = !stage_v_q || step_go;
  assign accept     = in_i.valid && in_i.ready;

  // a second result waits in the pending register
  assign push      = (step_go && step_cnt != 2'd0) || (pend_q && !fifo_full);
  assign push_data = pend_q ? pend_res_q : step_res0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_v_q    <= 1'b0;
      pend_q       <= 1'b0;
      state_q      <= '{mode: ModeLine, hdr: 1'b0, acc: '0, neg: 1'b0, dig: 1'b0,
                        held: '0, line: LineBits'(1), colc: '0};
    end else begin
      if (accept)       stage_v_q <= 1'b1;
      else if (step_go) stage_v_q <= 1'b0;
      if (step_go) state_q <= step_state;
      if (pend_q && !fifo_full)           pend_q <= 1'b0;
      else if (step_go && step_cnt == 2'd2) pend_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      stage_byte_q <= in_i.text_byte;
      stage_eoi_q  <= in_i.end_of_input;
    end
    if (step_go) pend_res_q <= step_res1;
  end

  dcp_res_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .full_o  (fifo_full),
    .valid_o (fifo_valid),
    .data_o  (fifo_data),
    .pop_i   (out_o.ready)
  );

  assign out_o.valid        = fifo_valid;
  assign out_o.kind         = fifo_data.kind;
  assign out_o.value        = fifo_data.value;
  assign out_o.clause_count = fifo_data.clause_count;
  assign out_o.error_code   = fifo_data.error_code;
  assign out_o.line_number  = fifo_data.line_number;
  assign out_o.column       = fifo_data.column;
  assign out_o.last_of_run  = fifo_data.last_of_run;

  `DCP_ASSERT_IMP(a_pend_halted, pend_q, state_q.mode == ModeHalt, "pending item while running")
  `DCP_ASSERT_IMP(a_halt_silent, step_go && state_q.mode == ModeHalt, step_cnt == 2'd0, "item after halt")
  `DCP_ASSERT_NXT(a_err_halts, push && push_data.kind == KindError, state_q.mode == ModeHalt, "no halt after error")
  `DCP_ASSERT_IMP(a_line_nonzero, stage_v_q, state_q.line != '0, "line counter at zero")

endmodule

FILE: tb/dimacs_cnf_stream_parser_unit_tb.sv
module dimacs_cnf_stream_parser_unit_tb;
  import dcp_pkg::*;

  localparam int     CycleLimit = 2_000_000;
  localparam longint MaxMag     = (64'd1 << MagW) - 1;
  localparam int     ScriptRows = 15;

  typedef struct {
    string text;
    bit    typed;
    kind_e kind;
    int    value;
    int    clauses;
  } script_row_t;

  typedef enum logic [1:0] {RxOpen, RxLight, RxHeavy, RxPulse} rx_pattern_e;

  // \001 stands for a nul byte, which a string cannot hold
  script_row_t script [ScriptRows] = '{
    '{"\n",                                1'b0, KindDone,      0,           0},
    '{" \t\n",                             1'b0, KindDone,      0,           0},
    '{"c \001\377\r\t%p\n",                1'b0, KindDone,      0,           0},
    '{" \tp\tcnf 2147483647  +2147483647\n", 1'b1, KindHeader, 2147483647, 2147483647},
    '{"2147483647 ",                       1'b1, KindLiteral,   2147483647,  0},
    '{"\t-2147483647\t",                   1'b1, KindLiteral,   -2147483647, 0},
    '{"+1 ",                               1'b1, KindLiteral,   1,           0},
    '{"-007 ",                             1'b1, KindLiteral,   -7,          0},
    '{"0 junk 5 x\n",                      1'b1, KindClauseEnd, 0,           0},
    '{"  0\n",                             1'b1, KindClauseEnd, 0,           0},
    '{" c comment\n",                      1'b0, KindDone,      0,           0},
    '{"9\t-8 +7 05\n",                     1'b0, KindDone,      0,           0},
    '{"c\n",                               1'b0, KindDone,      0,           0},
    '{"-1 00\n",                           1'b0, KindDone,      0,           0},
    '{"1 -2 3 0\n",                        1'b0, KindDone,      0,           0}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  dcp_in_if  in_if ();
  dcp_out_if out_if ();

  dimacs_cnf_stream_parser_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #4 clk_i = ~clk_i;

  // parser state as the decoder sees it
  mode_e                 pmode;
  logic                  hdr_seen;
  logic [MagW-1:0]       num_acc;
  logic                  num_neg;
  logic                  num_dig;
  logic [MagW-1:0]       var_count;
  logic [LineBits-1:0]   line_cnt;
  logic [ColumnBits-1:0] col_cnt;

  res_t decoded_items [$];
  res_t step_items [$];
  bit   typed_row;

  logic [8:0]  text_q [$];  // bit 8 marks end of input
  int          burst_left;
  int          mismatches;
  int          items_seen;
  int          cycle_count;
  rx_pattern_e rx_mode;
  int          rx_left;

  function automatic void emit(kind_e k, logic [ValueW-1:0] v = '0,
                               logic [CountW-1:0] cc = '0, err_e e = ErrDupHeader,
                               logic [LineOutW-1:0] ln = '0, logic [ColOutW-1:0] cl = '0);
    res_t r;
    r              = '0;
    r.kind         = k;
    r.value        = v;
    r.clause_count = cc;
    r.error_code   = e;
    r.line_number  = ln;
    r.column       = cl;
    step_items.insert(step_items.size(), r);
  endfunction

  function automatic void raise_error(err_e e, logic [ColumnBits-1:0] col);
    pmode = ModeHalt;
    emit(KindError, '0, '0, e, line_cnt, col);
  endfunction

  function automatic void clear_number();
    num_acc = '0;
    num_neg = 1'b0;
    num_dig = 1'b0;
  endfunction

  function automatic bit push_digit(logic [7:0] c);
    longint d;
    d = longint'(c) - longint'(ChZero);
    if (num_acc > (MaxMag - d) / 10) return 1'b0;
    num_acc = MagW'(num_acc * 10 + d);
    num_dig = 1'b1;
    return 1'b1;
  endfunction

  function automatic void close_header(logic [ColumnBits-1:0] col);
    logic [MagW-1:0] clauses;
    if (num_neg && num_acc != 0) begin
      raise_error(ErrNegClauses, col);
      return;
    end
    clauses = num_acc;
    clear_number();
    if (var_count == 0 || clauses == 0) begin
      pmode = ModeHalt;
      emit(KindTrivSat);
    end else begin
      pmode = ModeSkip;
      emit(KindHeader, {1'b0, var_count}, clauses);
    end
  endfunction

  function automatic void close_var_count(logic [ColumnBits-1:0] col, logic more);
    if (num_neg && num_acc != 0) begin
      raise_error(ErrNegVars, col);
      return;
    end
    var_count = num_acc;
    clear_number();
    if (more) pmode = ModeClsWs;
    else close_header(col);
  endfunction

  function automatic void decode_byte(logic [7:0] c, logic eoi);
    logic [ColumnBits-1:0] col;
    logic                  ws;
    logic                  dig;
    logic                  from_line;
    step_items.delete();
    if (pmode == ModeHalt) return;
    col = (col_cnt != '1) ? col_cnt + 1'b1 : col_cnt;
    if (eoi) begin
      case (pmode)
        ModeLine, ModeSkip:            emit(KindDone);
        ModeFmtWs, ModeFmtN, ModeFmtF: raise_error(ErrNotCnf, col);
        ModeVarsWs, ModeVars:          close_var_count(col, 1'b0);
        ModeClsWs, ModeCls:            close_header(col);
        default:                       raise_error(ErrNoTerm, col);
      endcase
      if (step_items.size() == 1 && step_items[0].kind == KindHeader) emit(KindDone);
      pmode = ModeHalt;
    end else begin
      col_cnt   = col;
      ws        = (c == ChSpace) || (c == ChTab);
      dig       = (c >= ChZero) && (c <= ChNine);
      from_line = (pmode == ModeLine);
      if (from_line && !ws && c != ChNl) begin
        if (c == ChC) pmode = ModeSkip;
        else if (c == ChPct) begin
          emit(KindDone);
          pmode = ModeHalt;
        end else if (c == ChP) begin
          if (hdr_seen) raise_error(ErrDupHeader, col);
          else begin
            hdr_seen = 1'b1;
            pmode    = ModeFmtWs;
          end
        end else if (!hdr_seen) raise_error(ErrNoHeader, col);
        else pmode = ModeClWs;
      end
      // the first byte of a clause line is also its first token byte
      if (!from_line || pmode == ModeClWs) begin
        case (pmode)
          ModeFmtWs: begin
            if (c == ChC) pmode = ModeFmtN;
            else if (!ws) raise_error(ErrNotCnf, col);
          end
          ModeFmtN: begin
            if (c == ChN) pmode = ModeFmtF;
            else raise_error(ErrNotCnf, col);
          end
          ModeFmtF: begin
            if (c == ChF) begin
              clear_number();
              pmode = ModeVarsWs;
            end else raise_error(ErrNotCnf, col);
          end
          ModeVarsWs, ModeClsWs: begin
            if (c == ChMinus || c == ChPlus) begin
              num_neg = (c == ChMinus);
              pmode   = (pmode == ModeVarsWs) ? ModeVars : ModeCls;
            end else if (dig) begin
              if (!push_digit(c)) raise_error(ErrOverflow, col);
              else pmode = (pmode == ModeVarsWs) ? ModeVars : ModeCls;
            end else if (!ws) begin
              if (pmode == ModeVarsWs) close_var_count(col, 1'b0);
              else close_header(col);
            end
          end
          ModeVars: begin
            if (dig) begin
              if (!push_digit(c)) raise_error(ErrOverflow, col);
            end else close_var_count(col, ws);
          end
          ModeCls: begin
            if (dig) begin
              if (!push_digit(c)) raise_error(ErrOverflow, col);
            end else close_header(col);
          end
          ModeClWs: begin
            if (c == ChNl) raise_error(ErrNoTerm, col);
            else if (c == ChZero) begin
              emit(KindClauseEnd);
              pmode = ModeSkip;
            end else if (c == ChMinus || c == ChPlus) begin
              clear_number();
              num_neg = (c == ChMinus);
              pmode   = ModeLit;
            end else if (dig) begin
              clear_number();
              void'(push_digit(c));
              pmode = ModeLit;
            end else if (!ws) raise_error(ErrBadLiteral, col);
          end
          ModeLit: begin
            if (dig) begin
              if (!push_digit(c)) raise_error(ErrOverflow, col);
            end else if (ws) begin
              if (!num_dig || num_acc == 0) raise_error(ErrBadLiteral, col);
              else begin
                emit(KindLiteral, num_neg ? -{1'b0, num_acc} : {1'b0, num_acc});
                clear_number();
                pmode = ModeClWs;
              end
            end else if (c == ChNl) raise_error(ErrNoTerm, col);
            else raise_error(ErrBadLiteral, col);
          end
          default: ;
        endcase
      end
      if (c == ChNl && pmode != ModeHalt) begin
        pmode = ModeLine;
        if (line_cnt != '1) line_cnt = line_cnt + 1'b1;
        col_cnt = '0;
      end
    end
    if (step_items.size() != 0) step_items[step_items.size() - 1].last_of_run = 1'b1;
    if (!typed_row) begin
      foreach (step_items[i]) decoded_items.insert(decoded_items.size(), step_items[i]);
    end
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) text_q.insert(text_q.size(), {1'b0, s[i]});
  endfunction

  function automatic void push_blanks(int lo, int hi);
    repeat ($urandom_range(lo, hi))
      text_q.insert(text_q.size(), {1'b0, $urandom_range(0, 1) ? ChSpace : ChTab});
  endfunction

  // any byte but a line end
  function automatic void push_junk(int n);
    logic [7:0] b;
    repeat (n) begin
      b = 8'($urandom_range(0, 254));
      if (b >= ChNl) b = b + 1'b1;
      text_q.insert(text_q.size(), {1'b0, b});
    end
  endfunction

  function automatic void push_eoi();
    text_q.insert(text_q.size(), {1'b1, 8'($urandom_range(0, 255))});
  endfunction

  function automatic void push_literal();
    int unsigned mag;
    int          sgn;
    sgn = $urandom_range(0, 3);
    if (sgn == 2) push_text("-");
    else if (sgn == 3) push_text("+");
    if (sgn >= 2 && $urandom_range(0, 3) == 0) push_text("00");
    case ($urandom_range(0, 7))
      0:       mag = 32'h7fff_ffff - $urandom_range(0, 2);
      1:       mag = $urandom_range(1, 32'h7fff_ffff);
      default: mag = $urandom_range(1, 40);
    endcase
    push_text($sformatf("%0d", mag));
  endfunction

  function automatic void push_clause_line();
    push_blanks(0, 2);
    repeat ($urandom_range(0, 4)) begin
      push_literal();
      push_blanks(1, 2);
    end
    push_text("0");
    if ($urandom_range(0, 2) == 0) begin
      push_blanks(0, 1);
      push_junk($urandom_range(0, 6));
    end
    push_text("\n");
  endfunction

  task automatic send_char(logic [7:0] b, logic eoi, bit drain);
    int gap;
    gap = 0;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 2) != 0) gap = $urandom_range(1, 5);
    end
    if (drain && gap == 0) gap = 1;
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      // hold off until every decoded item has come out
      while (drain && decoded_items.size() != 0) @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.text_byte    <= b;
    in_if.end_of_input <= eoi;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    decode_byte(b, eoi);
    burst_left--;
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    mismatches++;
    if (mismatches <= 200)
      $display("mismatch on item %0d: %s = %0d, expected %0d", items_seen, what, got, want);
  endtask

  task automatic check_item();
    res_t want;
    items_seen++;
    if (decoded_items.size() == 0) begin
      report_mismatch("unexpected item, kind", out_if.kind, -1);
      return;
    end
    want = decoded_items.pop_front();
    if (out_if.kind !== want.kind) report_mismatch("kind", out_if.kind, want.kind);
    if (out_if.value !== want.value) report_mismatch("value", out_if.value, want.value);
    if (out_if.clause_count !== want.clause_count)
      report_mismatch("clause_count", out_if.clause_count, want.clause_count);
    if (out_if.error_code !== want.error_code)
      report_mismatch("error_code", out_if.error_code, want.error_code);
    if (out_if.line_number !== want.line_number)
      report_mismatch("line_number", out_if.line_number, want.line_number);
    if (out_if.column !== want.column) report_mismatch("column", out_if.column, want.column);
    if (out_if.last_of_run !== want.last_of_run)
      report_mismatch("last_of_run", out_if.last_of_run, want.last_of_run);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) check_item();
      if (rx_left <= 0) begin
        rx_mode = rx_pattern_e'($urandom_range(0, 3));
        rx_left = $urandom_range(16, 128);
      end
      rx_left--;
      case (rx_mode)
        RxOpen:  out_if.ready <= 1'b1;
        RxLight: out_if.ready <= ($urandom_range(0, 3) != 0);
        RxHeavy: out_if.ready <= ($urandom_range(0, 3) == 0);
        default: out_if.ready <= (rx_left[2:0] == 3'd0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int   row;
    int   k;
    res_t want;
    logic [7:0] ch;

    rst_ni             = 1'b0;
    in_if.valid        = 1'b0;
    in_if.text_byte    = '0;
    in_if.end_of_input = 1'b0;
    out_if.ready       = 1'b0;
    pmode              = ModeLine;
    hdr_seen           = 1'b0;
    num_acc            = '0;
    num_neg            = 1'b0;
    num_dig            = 1'b0;
    var_count          = '0;
    line_cnt           = LineBits'(1);
    col_cnt            = '0;
    typed_row          = 1'b0;
    burst_left         = 0;
    mismatches         = 0;
    items_seen         = 0;
    cycle_count        = 0;
    rx_left            = 0;
    rx_mode            = RxOpen;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (row = 0; row < ScriptRows; row++) begin
      if (script[row].typed) begin
        want              = '0;
        want.kind         = script[row].kind;
        want.value        = script[row].value;
        want.clause_count = CountW'(script[row].clauses);
        want.error_code   = ErrDupHeader;
        want.last_of_run  = 1'b1;
        decoded_items.insert(decoded_items.size(), want);
      end
      typed_row = script[row].typed;
      for (k = 0; k < script[row].text.len(); k++) begin
        ch = script[row].text[k];
        send_char((ch == 8'h01) ? 8'h00 : ch, 1'b0, 1'b0);
      end
    end
    typed_row = 1'b0;

    // well-formed document body
    while (text_q.size() < 360) begin
      case ($urandom_range(0, 19))
        0, 1, 2: begin
          push_blanks(0, 1);
          push_text("c");
          push_junk($urandom_range(0, 10));
          push_text("\n");
        end
        3, 4: begin
          push_blanks(0, 3);
          push_text("\n");
        end
        default: push_clause_line();
      endcase
    end

    // how the document ends: done, or the first error
    case ($urandom_range(0, 9))
      0: push_eoi();
      1: begin
        push_blanks(0, 2);
        push_text("%");
      end
      2: begin
        push_text("3 -4");
        push_eoi();
      end
      3: push_text("5 \n");
      4: begin
        push_blanks(0, 1);
        push_text("p cnf 1 1\n");
      end
      5: begin
        case ($urandom_range(0, 4))
          0:       push_text("1 -0 ");
          1:       push_text("+\t");
          2:       push_text("9a");
          3:       push_text("q");
          default: push_text("2\r\n");
        endcase
      end
      6: push_text($urandom_range(0, 1) ? "2147483648 " : "-99999999999");
      7: begin
        push_text("c ");
        push_junk($urandom_range(0, 5));
        push_eoi();
      end
      8: begin
        // a long run of blanks ahead of a bad token
        push_text("1");
        push_blanks(20, 60);
        push_text("z");
      end
      default: begin
        repeat ($urandom_range(1, 12)) begin
          case ($urandom_range(0, 5))
            0:       push_text("-");
            1:       push_text("\n");
            2:       push_blanks(1, 1);
            3:       push_text("0");
            4:       push_text($sformatf("%0d", $urandom_range(1, 9)));
            default: push_junk(1);
          endcase
        end
        push_eoi();
      end
    endcase

    // the halted parser must stay silent
    push_junk(6);
    text_q.insert(text_q.size(), {1'b0, ChNl});
    push_eoi();

    foreach (text_q[i])
      send_char(text_q[i][7:0], text_q[i][8], (i == 0) || ($urandom_range(0, 299) == 0));
    in_if.valid <= 1'b0;

    while (decoded_items.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
